### src/esd_pkg.sv
// Shared types, codes and reset values of the escaped stream deframer.
package esd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 9;
  localparam int KIND_W    = 3;
  localparam int REASON_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int RES_MAX   = 3;
  localparam int RES_CNT_W = 2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SERIAL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ABORT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STRAY  = 3'd4;

  // abort reasons
  localparam logic [REASON_W-1:0] REASON_NONE     = 3'd0;
  localparam logic [REASON_W-1:0] REASON_DBL_ESC  = 3'd1;
  localparam logic [REASON_W-1:0] REASON_DBL_SOF  = 3'd2;
  localparam logic [REASON_W-1:0] REASON_BAD_ESC  = 3'd3;
  localparam logic [REASON_W-1:0] REASON_OVERFLOW = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LITERAL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_GAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_END        = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] escape_code;
    logic [BYTE_W-1:0] literal_code;
    logic [BYTE_W-1:0] reserved_code;
    logic [BYTE_W-1:0] serial_gap_code;
    logic [BYTE_W-1:0] frame_gap_code;
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    escape_code:     8'd254,
    literal_code:    8'd248,
    reserved_code:   8'd249,
    serial_gap_code: 8'd250,
    frame_gap_code:  8'd251,
    start_code:      8'd252,
    end_code:        8'd253
  };

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_W-1:0]    frame_length;
    logic [REASON_W-1:0] abort_reason;
  } res_t;

  // all results caused by one item, slot 0 first
  typedef struct packed {
    res_t [RES_MAX-1:0]   res;
    logic [RES_CNT_W-1:0] n;
  } bundle_t;

  function automatic res_t mk_res(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                  logic [LEN_W-1:0] len, logic [REASON_W-1:0] reason);
    res_t r;
    r.kind         = kind;
    r.data_byte    = data;
    r.frame_length = len;
    r.abort_reason = reason;
    return r;
  endfunction

endpackage

### src/esd_decode.sv
// Decoder: one item plus the current state gives the result bundle and next state.
module esd_decode #(
  parameter int FRAME_BYTES_MAX = 256,
  parameter int CNT_W           = 9
) (
  input  esd_pkg::cfg_t                cfg,
  input  logic [esd_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                         after_escape,
  input  logic                         in_frame,
  input  logic [CNT_W-1:0]             frame_count,
  output esd_pkg::bundle_t             bundle,
  output logic                         after_escape_nxt,
  output logic                         in_frame_nxt,
  output logic [CNT_W-1:0]             frame_count_nxt
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_BYTES_MAX);

  always_comb begin
    logic [esd_pkg::BYTE_W-1:0]    c;
    logic                          ae;
    logic                          inf;
    logic [CNT_W-1:0]              cnt;
    logic                          deliver;
    logic [esd_pkg::RES_CNT_W-1:0] n;
    esd_pkg::res_t [esd_pkg::RES_MAX-1:0] res;

    c       = rx_byte;
    ae      = after_escape;
    inf     = in_frame;
    cnt     = frame_count;
    deliver = 1'b1;
    n       = '0;
    res     = '0;

    if (ae) begin
      if (c == cfg.escape_code) begin
        // doubled escape: stay after-escape, drop a frame in progress
        if (inf) begin
          res[n]  = esd_pkg::mk_res(esd_pkg::KIND_ABORT, '0, '0, esd_pkg::REASON_DBL_ESC);
          n       = n + 2'd1;
          inf     = 1'b0;
          cnt     = '0;
          deliver = 1'b0;
        end
      end else begin
        ae = 1'b0;
        priority if (c == cfg.literal_code) begin
          c = cfg.escape_code;
        end else if (c == cfg.start_code) begin
          if (cnt != '0) begin
            res[n] = esd_pkg::mk_res(esd_pkg::KIND_ABORT, '0, '0, esd_pkg::REASON_DBL_SOF);
            n      = n + 2'd1;
            cnt    = '0;
          end
          inf     = 1'b1;
          deliver = 1'b0;
        end else if (c == cfg.end_code) begin
          if (inf) begin
            res[n] = esd_pkg::mk_res(esd_pkg::KIND_END, '0, esd_pkg::LEN_W'(cnt),
                                     esd_pkg::REASON_NONE);
            inf    = 1'b0;
            cnt    = '0;
          end else begin
            res[n] = esd_pkg::mk_res(esd_pkg::KIND_STRAY, '0, '0, esd_pkg::REASON_NONE);
          end
          n       = n + 2'd1;
          deliver = 1'b0;
        end else if (c == cfg.reserved_code || c == cfg.serial_gap_code ||
                     c == cfg.frame_gap_code) begin
          deliver = 1'b0;
        end else begin
          // unknown code: abort any frame, pass escape and code as serial bytes
          if (inf) begin
            res[n] = esd_pkg::mk_res(esd_pkg::KIND_ABORT, '0, '0, esd_pkg::REASON_BAD_ESC);
            n      = n + 2'd1;
            inf    = 1'b0;
            cnt    = '0;
          end
          res[n] = esd_pkg::mk_res(esd_pkg::KIND_SERIAL, cfg.escape_code, '0,
                                   esd_pkg::REASON_NONE);
          n      = n + 2'd1;
        end
      end
    end else if (c == cfg.escape_code) begin
      ae      = 1'b1;
      deliver = 1'b0;
    end

    if (deliver) begin
      if (inf) begin
        if (cnt >= CNT_MAX) begin
          res[n] = esd_pkg::mk_res(esd_pkg::KIND_ABORT, '0, '0, esd_pkg::REASON_OVERFLOW);
          inf    = 1'b0;
          cnt    = '0;
        end else begin
          res[n] = esd_pkg::mk_res(esd_pkg::KIND_FRAME, c, '0, esd_pkg::REASON_NONE);
          cnt    = cnt + CNT_W'(1);
        end
      end else begin
        res[n] = esd_pkg::mk_res(esd_pkg::KIND_SERIAL, c, '0, esd_pkg::REASON_NONE);
      end
      n = n + 2'd1;
    end

    bundle.res       = res;
    bundle.n         = n;
    after_escape_nxt = ae;
    in_frame_nxt     = inf;
    frame_count_nxt  = cnt;
  end

endmodule

### src/esd_emit.sv
// Result register: holds a bundle, hands out one result per unstalled cycle.
module esd_emit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load_valid,
  output logic                           load_ready,
  input  esd_pkg::bundle_t               load_bundle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output esd_pkg::res_t                  out_res,
  output logic                           out_last
);

  logic                          valid_r, valid_nxt;
  logic [esd_pkg::RES_CNT_W-1:0] idx_r, idx_nxt;
  esd_pkg::bundle_t              bundle_r;
  logic                          out_fire;
  logic                          load;

  assign out_valid  = valid_r;
  assign out_res    = bundle_r.res[idx_r];
  assign out_last   = (idx_r == bundle_r.n - 2'd1);
  assign out_fire   = valid_r && !out_stall;
  assign load_ready = !valid_r || (out_fire && out_last);
  assign load       = load_valid && load_ready;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (out_fire) begin
      if (out_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bundle_r <= load_bundle;
    end
  end

endmodule

### src/escaped_stream_deframer.sv
// Top level of the escaped stream deframer: input register, state, config, result register.
//
// Splits a received link byte stream into plain serial bytes and escape-delimited
// frames. Input channel: in_valid / in_stall with in_rx_byte and in_transfer_last
// (the latter is carried for the link but has no effect on decoding). Result
// channel: out_valid / out_stall with kind, data byte, frame length, abort reason
// and a last flag on the final result caused by each input item.
// Configuration: cfg_valid / cfg_ready (always ready) writes cfg_data into the
// code register selected by cfg_index; index 7 is ignored. Write only while idle.
// An accepted item is decoded out of the input register; its results are loaded
// into the result register, which presents them. Throughput: one item per cycle
// while each item causes at most one result and the receiver does not stall; an
// item with several results holds the result register until the single result
// port has handed each out. Items that cause no result never touch the result register.
// Reset (synchronous, rst_n low): code registers go to their default values, the
// after-escape flag, in-frame flag and frame byte count clear, both the input and
// result registers empty. When the receiver stalls, the current result holds,
// and one more item waits in the input register before in_stall rises.
module escaped_stream_deframer #(
  parameter int FRAME_BYTES_MAX = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [esd_pkg::BYTE_W-1:0]      in_rx_byte,
  input  logic                            in_transfer_last,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [esd_pkg::KIND_W-1:0]      out_kind,
  output logic [esd_pkg::BYTE_W-1:0]      out_data_byte,
  output logic [esd_pkg::LEN_W-1:0]       out_frame_length,
  output logic [esd_pkg::REASON_W-1:0]    out_abort_reason,
  output logic                            out_last,
  // configuration write port
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [esd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esd_pkg::BYTE_W-1:0]      cfg_data
);

  // count must hold FRAME_BYTES_MAX itself
  localparam int CNT_W = $clog2(FRAME_BYTES_MAX + 1);

  esd_pkg::cfg_t              cfg_r, cfg_nxt;
  logic                       in_full_r, in_full_nxt;
  logic [esd_pkg::BYTE_W-1:0] in_byte_r;
  logic                       after_escape_r, after_escape_nxt;
  logic                       in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]           frame_count_r, frame_count_nxt;

  esd_pkg::bundle_t           dec_bundle;
  esd_pkg::res_t              out_res;
  logic                       emit_ready;
  logic                       emit_load;
  logic                       consume;
  logic                       in_load;

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        esd_pkg::CFG_ESCAPE:     cfg_nxt.escape_code     = cfg_data;
        esd_pkg::CFG_LITERAL:    cfg_nxt.literal_code    = cfg_data;
        esd_pkg::CFG_RESERVED:   cfg_nxt.reserved_code   = cfg_data;
        esd_pkg::CFG_SERIAL_GAP: cfg_nxt.serial_gap_code = cfg_data;
        esd_pkg::CFG_FRAME_GAP:  cfg_nxt.frame_gap_code  = cfg_data;
        esd_pkg::CFG_START:      cfg_nxt.start_code      = cfg_data;
        esd_pkg::CFG_END:        cfg_nxt.end_code        = cfg_data;
        default:                 cfg_nxt                 = cfg_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. Advance the held item into the decoder whenever its
  // results (if any) fit into the result register this cycle.
  // ---------------------------------------------------------------------------
  esd_decode #(
    .FRAME_BYTES_MAX (FRAME_BYTES_MAX),
    .CNT_W           (CNT_W)
  ) u_decode (
    .cfg              (cfg_r),
    .rx_byte          (in_byte_r),
    .after_escape     (after_escape_r),
    .in_frame         (in_frame_r),
    .frame_count      (frame_count_r),
    .bundle           (dec_bundle),
    .after_escape_nxt (after_escape_nxt),
    .in_frame_nxt     (in_frame_nxt),
    .frame_count_nxt  (frame_count_nxt)
  );

  assign emit_load   = in_full_r && (dec_bundle.n != '0);
  assign consume     = in_full_r && ((dec_bundle.n == '0) || emit_ready);
  assign in_stall    = in_full_r && !consume;
  assign in_load     = in_valid && !in_stall;
  assign in_full_nxt = in_load || (in_full_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r          <= esd_pkg::CFG_RESET;
      in_full_r      <= 1'b0;
      after_escape_r <= 1'b0;
      in_frame_r     <= 1'b0;
      frame_count_r  <= '0;
    end else begin
      cfg_r     <= cfg_nxt;
      in_full_r <= in_full_nxt;
      // commit decoder state only when the item leaves the input register
      if (consume) begin
        after_escape_r <= after_escape_nxt;
        in_frame_r     <= in_frame_nxt;
        frame_count_r  <= frame_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register and per-result sequencing.
  // ---------------------------------------------------------------------------
  esd_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_valid  (emit_load),
    .load_ready  (emit_ready),
    .load_bundle (dec_bundle),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res),
    .out_last    (out_last)
  );

  assign out_kind         = out_res.kind;
  assign out_data_byte    = out_res.data_byte;
  assign out_frame_length = out_res.frame_length;
  assign out_abort_reason = out_res.abort_reason;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a held byte count implies an open frame
  a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_count_r != '0) |-> in_frame_r)
    else $error("frame count nonzero outside a frame");

  // the count never passes the frame limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    frame_count_r <= CNT_W'(FRAME_BYTES_MAX))
    else $error("frame count above limit");

  // an item with results only leaves when the result register takes them
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && emit_load) |=> out_valid)
    else $error("results of a consumed item were lost");

endmodule

### tb/sv/escaped_stream_deframer_test.sv
// Self-checking testbench for the escaped stream deframer: directed and random link bytes.
module escaped_stream_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 10;
  localparam int FRAME_MAX   = 256;
  localparam int QUIET_TICKS = 8;        // idle ticks past the two-stage pipeline
  localparam int CYCLE_LIMIT = 400_000;

  // index 7 selects no register and must be ignored
  localparam logic [esd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // one result still owed by the block, with its last flag
  typedef struct {
    esd_pkg::res_t r;
    logic          last;
  } due_t;

  // Tracks the decoder state, predicts the results of each accepted byte and
  // compares them in order against what the block delivers.
  class deframe_checker;
    esd_pkg::cfg_t codes;
    bit            after_esc;
    bit            in_frame;
    int unsigned   held;
    esd_pkg::res_t step_res[$];
    due_t          due[$];
    int            fails;

    function new();
      codes     = esd_pkg::CFG_RESET;
      after_esc = 1'b0;
      in_frame  = 1'b0;
      held      = 0;
      fails     = 0;
    endfunction

    function void set_reg(logic [esd_pkg::CFG_IDX_W-1:0] idx,
                          logic [esd_pkg::BYTE_W-1:0] val);
      case (idx)
        esd_pkg::CFG_ESCAPE:     codes.escape_code     = val;
        esd_pkg::CFG_LITERAL:    codes.literal_code    = val;
        esd_pkg::CFG_RESERVED:   codes.reserved_code   = val;
        esd_pkg::CFG_SERIAL_GAP: codes.serial_gap_code = val;
        esd_pkg::CFG_FRAME_GAP:  codes.frame_gap_code  = val;
        esd_pkg::CFG_START:      codes.start_code      = val;
        esd_pkg::CFG_END:        codes.end_code        = val;
        default: ;
      endcase
    endfunction

    function void emit(logic [esd_pkg::KIND_W-1:0] kind, logic [esd_pkg::BYTE_W-1:0] data,
                       logic [esd_pkg::LEN_W-1:0] len,
                       logic [esd_pkg::REASON_W-1:0] reason);
      if (step_res.size() < esd_pkg::RES_MAX)
        step_res.push_back(esd_pkg::res_t'{kind, data, len, reason});
    endfunction

    function void drop_frame(logic [esd_pkg::REASON_W-1:0] reason);
      in_frame = 1'b0;
      held     = 0;
      emit(esd_pkg::KIND_ABORT, '0, '0, reason);
    endfunction

    function void note_byte(logic [esd_pkg::BYTE_W-1:0] rx);
      logic [esd_pkg::BYTE_W-1:0] c;
      bit deliver;
      c       = rx;
      deliver = 1'b1;
      step_res.delete();
      if (after_esc) begin
        if (c == codes.escape_code) begin
          // doubled escape: kill a frame, stay waiting for a code either way
          if (in_frame) begin
            drop_frame(esd_pkg::REASON_DBL_ESC);
            deliver = 1'b0;
          end
        end else begin
          after_esc = 1'b0;
          if (c == codes.literal_code) begin
            c = codes.escape_code;
          end else if (c == codes.start_code) begin
            if (held != 0)
              drop_frame(esd_pkg::REASON_DBL_SOF);
            in_frame = 1'b1;
            deliver  = 1'b0;
          end else if (c == codes.end_code) begin
            if (in_frame) begin
              emit(esd_pkg::KIND_END, '0, held[esd_pkg::LEN_W-1:0], esd_pkg::REASON_NONE);
              in_frame = 1'b0;
              held     = 0;
            end else begin
              emit(esd_pkg::KIND_STRAY, '0, '0, esd_pkg::REASON_NONE);
            end
            deliver = 1'b0;
          end else if (c == codes.reserved_code || c == codes.serial_gap_code ||
                       c == codes.frame_gap_code) begin
            deliver = 1'b0;
          end else begin
            // unknown code: abort any frame, then pass escape and code on as serial bytes
            if (in_frame)
              drop_frame(esd_pkg::REASON_BAD_ESC);
            emit(esd_pkg::KIND_SERIAL, codes.escape_code, '0, esd_pkg::REASON_NONE);
          end
        end
      end else if (c == codes.escape_code) begin
        after_esc = 1'b1;
        deliver   = 1'b0;
      end

      if (deliver) begin
        if (!in_frame) begin
          emit(esd_pkg::KIND_SERIAL, c, '0, esd_pkg::REASON_NONE);
        end else if (held >= FRAME_MAX) begin
          drop_frame(esd_pkg::REASON_OVERFLOW);
        end else begin
          emit(esd_pkg::KIND_FRAME, c, '0, esd_pkg::REASON_NONE);
          held++;
        end
      end

      foreach (step_res[i])
        due.push_back(due_t'{step_res[i], (i == step_res.size() - 1)});
    endfunction

    task report(string what);
      fails++;
      $display("[%0t] error: %s", $time, what);
    endtask

    task check_result(esd_pkg::res_t got, logic got_last);
      due_t want;
      if (due.size() == 0) begin
        report($sformatf("result of kind %0d arrived with nothing pending", got.kind));
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.r.kind)
        report($sformatf("kind got %0d want %0d", got.kind, want.r.kind));
      if (got.data_byte !== want.r.data_byte)
        report($sformatf("data_byte got %0h want %0h", got.data_byte, want.r.data_byte));
      if (got.frame_length !== want.r.frame_length)
        report($sformatf("frame_length got %0d want %0d",
                         got.frame_length, want.r.frame_length));
      if (got.abort_reason !== want.r.abort_reason)
        report($sformatf("abort_reason got %0d want %0d",
                         got.abort_reason, want.r.abort_reason));
      if (got_last !== want.last)
        report($sformatf("last got %0b want %0b", got_last, want.last));
    endtask
  endclass

  logic                          clk              = 1'b0;
  logic                          rst_n            = 1'b0;
  logic                          in_valid         = 1'b0;
  logic                          in_stall;
  logic [esd_pkg::BYTE_W-1:0]    in_rx_byte       = '0;
  logic                          in_transfer_last = 1'b0;
  logic                          out_valid;
  logic                          out_stall        = 1'b0;
  logic [esd_pkg::KIND_W-1:0]    out_kind;
  logic [esd_pkg::BYTE_W-1:0]    out_data_byte;
  logic [esd_pkg::LEN_W-1:0]     out_frame_length;
  logic [esd_pkg::REASON_W-1:0]  out_abort_reason;
  logic                          out_last;
  logic                          cfg_valid        = 1'b0;
  logic                          cfg_ready;
  logic [esd_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
  logic [esd_pkg::BYTE_W-1:0]    cfg_data         = '0;

  deframe_checker chk = new();

  bit in_jitter  = 1'b1;   // sender inserts random gaps
  bit out_jitter = 1'b1;   // receiver stalls at random
  int items_sent = 0;
  int cycles     = 0;

  escaped_stream_deframer #(
    .FRAME_BYTES_MAX(FRAME_MAX)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_transfer_last (in_transfer_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length),
    .out_abort_reason (out_abort_reason),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop: nothing in a correct run comes close to this many cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("escaped_stream_deframer: mismatch");
      $finish;
    end
  end

  // Receiver: stall about one cycle in five while jitter is on.
  always @(posedge clk)
    out_stall <= out_jitter && ($urandom_range(99) < 20);

  // Sample the result channel with the values the block saw at this edge.
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      chk.check_result(esd_pkg::res_t'{out_kind, out_data_byte, out_frame_length,
                                       out_abort_reason},
                       out_last);

  // Present one item, hold it through stalls, note it once accepted.
  // Leave in_valid high on return so back-to-back items need no extra edge.
  task automatic send_byte(input logic [esd_pkg::BYTE_W-1:0] b);
    while (in_jitter && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_rx_byte       <= b;
    in_transfer_last <= 1'($urandom_range(1));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.note_byte(b);
    items_sent++;
  endtask

  task automatic send_escape(input logic [esd_pkg::BYTE_W-1:0] code);
    send_byte(chk.codes.escape_code);
    send_byte(code);
  endtask

  // Payload byte with the escape byte stuffed as escape + literal.
  task automatic send_payload(input logic [esd_pkg::BYTE_W-1:0] b);
    if (b == chk.codes.escape_code)
      send_escape(chk.codes.literal_code);
    else
      send_byte(b);
  endtask

  // Drop valid and wait out every owed result plus the pipeline tail.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (chk.due.size() != 0) @(posedge clk);
    repeat (QUIET_TICKS) @(posedge clk);
  endtask

  // Hold valid until the write is taken; the caller drops valid after the last one.
  task automatic write_reg(input logic [esd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [esd_pkg::BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chk.set_reg(idx, val);
  endtask

  // Rewrite every code register; the unused index goes first and must change nothing.
  task automatic load_codes(input esd_pkg::cfg_t c);
    write_reg(CFG_UNUSED, 8'($urandom_range(255)));
    write_reg(esd_pkg::CFG_ESCAPE,     c.escape_code);
    write_reg(esd_pkg::CFG_LITERAL,    c.literal_code);
    write_reg(esd_pkg::CFG_RESERVED,   c.reserved_code);
    write_reg(esd_pkg::CFG_SERIAL_GAP, c.serial_gap_code);
    write_reg(esd_pkg::CFG_FRAME_GAP,  c.frame_gap_code);
    write_reg(esd_pkg::CFG_START,      c.start_code);
    write_reg(esd_pkg::CFG_END,        c.end_code);
    cfg_valid <= 1'b0;
  endtask

  // Favor the active codes so the decoder branches get hit often.
  function automatic logic [esd_pkg::BYTE_W-1:0] any_byte();
    case ($urandom_range(9))
      0:       return chk.codes.escape_code;
      1:       return chk.codes.literal_code;
      2:       return chk.codes.start_code;
      3:       return chk.codes.end_code;
      4:       return $urandom_range(1) ? chk.codes.reserved_code : chk.codes.serial_gap_code;
      5:       return chk.codes.frame_gap_code;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed frames and serial runs with random content; the rest is
  // broken frames, raw noise and an occasional full drain.
  task automatic random_run(input int budget);
    int stop_at;
    int n;
    int pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(19);
      if (pick < 9) begin
        send_escape(chk.codes.start_code);
        n = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(6);
        repeat (n) begin
          if ($urandom_range(11) == 0)
            send_escape(chk.codes.frame_gap_code);
          send_payload(any_byte());
        end
        send_escape(chk.codes.end_code);
      end else if (pick < 13) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(11) == 0)
            send_escape(chk.codes.serial_gap_code);
          send_payload(any_byte());
        end
      end else if (pick < 17) begin
        send_escape(chk.codes.start_code);
        repeat ($urandom_range(3)) send_payload(any_byte());
        case ($urandom_range(3))
          0: send_escape(chk.codes.start_code);
          1: begin
            // doubled escape, then whatever code follows
            send_byte(chk.codes.escape_code);
            send_escape(any_byte());
          end
          2: send_escape(any_byte());
          default: ;  // leave the frame open for the next start
        endcase
      end else if (pick < 19) begin
        repeat ($urandom_range(1, 6)) send_byte(any_byte());
      end else begin
        wait_quiet();
      end
    end
  endtask

  initial begin
    esd_pkg::cfg_t c;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset codes.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_escape(chk.codes.literal_code);   // literal escape as a serial byte
    send_escape(chk.codes.end_code);       // end outside a frame
    send_escape(chk.codes.start_code);
    send_escape(chk.codes.start_code);     // start again with nothing held
    send_byte(8'h00);
    send_byte(8'hFF);
    send_escape(chk.codes.literal_code);   // stuffed escape inside the frame
    send_escape(chk.codes.start_code);     // second start with bytes held
    send_byte(8'h5A);
    send_escape(chk.codes.end_code);
    send_escape(chk.codes.start_code);
    send_byte(chk.codes.escape_code);
    send_byte(chk.codes.escape_code);      // doubled escape inside a frame
    send_byte(chk.codes.escape_code);      // doubled escape outside a frame
    send_byte(chk.codes.literal_code);
    send_escape(chk.codes.start_code);
    send_escape(8'h11);                    // unknown code inside a frame

    // Fill a frame to the limit; the next byte overflows it and the end is stray.
    send_escape(chk.codes.start_code);
    repeat (FRAME_MAX) send_payload(8'($urandom_range(255)));
    send_payload(8'h3C);
    send_escape(chk.codes.end_code);

    random_run(30);
    wait_quiet();

    // Codes at the low and high ends; run without any idling on either side.
    c = '{escape_code: 8'h00, literal_code: 8'hFF, reserved_code: 8'h01,
          serial_gap_code: 8'h80, frame_gap_code: 8'h7F, start_code: 8'hFE,
          end_code: 8'hFD};
    load_codes(c);
    in_jitter  = 1'b0;
    out_jitter = 1'b0;
    random_run(60);
    wait_quiet();
    in_jitter  = 1'b1;
    out_jitter = 1'b1;

    c = '{escape_code: 8'hFF, literal_code: 8'h00, reserved_code: 8'hFE,
          serial_gap_code: 8'h01, frame_gap_code: 8'h02, start_code: 8'h03,
          end_code: 8'h80};
    load_codes(c);
    random_run(30);
    wait_quiet();

    // Colliding codes: escape shadows serial gap, literal shadows reserved,
    // start shadows frame gap.
    c = '{escape_code: 8'h7E, literal_code: 8'h5E, reserved_code: 8'h5E,
          serial_gap_code: 8'h7E, frame_gap_code: 8'hAA, start_code: 8'hAA,
          end_code: 8'h5D};
    load_codes(c);
    random_run(30);
    wait_quiet();

    c.escape_code     = 8'($urandom_range(255));
    c.literal_code    = 8'($urandom_range(255));
    c.reserved_code   = 8'($urandom_range(255));
    c.serial_gap_code = 8'($urandom_range(255));
    c.frame_gap_code  = 8'($urandom_range(255));
    c.start_code      = 8'($urandom_range(255));
    c.end_code        = 8'($urandom_range(255));
    load_codes(c);
    random_run(30);
    wait_quiet();

    if (chk.fails == 0)
      $display("escaped_stream_deframer: match");
    else
      $display("escaped_stream_deframer: mismatch");
    $finish;
  end

endmodule
